// ----- sv/vdi_pkg.sv -----
// Package for the vertex deduplication indexer.
// Holds sizes, the sequencer state type and the coordinate helper.
// No dependencies.
package vdi_pkg;
   localparam int MaxVertices = 1024;
   localparam int AddrW = $clog2(MaxVertices);
   localparam int CountW = AddrW + 1;
   localparam int IndexW = 10;
   localparam int CoordW = 32;
   localparam logic ActClear = 1'b0;
   localparam logic ActVertex = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [CoordW-1:0] x;
      logic [CoordW-1:0] y;
      logic [CoordW-1:0] z;
   } pos_type;

   // Fold minus zero onto plus zero.
   function automatic logic [CoordW-1:0] canon_zero(input logic [CoordW-1:0] v);
      logic [CoordW-1:0] r;
      r = v;
      if (v == {1'b1, {(CoordW-1){1'b0}}}) r = '0;
      return r;
   endfunction
endpackage

// ----- sv/vdi_if.sv -----
// Valid/ready channel interfaces for request and response.
// No dependencies.
interface vdi_req_if;
   logic valid;
   logic ready;
   logic action;
   logic [31:0] pos_x;
   logic [31:0] pos_y;
   logic [31:0] pos_z;
   modport source (output valid, action, pos_x, pos_y, pos_z, input ready);
   modport sink (input valid, action, pos_x, pos_y, pos_z, output ready);
endinterface

interface vdi_rsp_if;
   logic valid;
   logic ready;
   logic [9:0] vert_idx;
   logic is_new;
   logic table_full;
   modport source (output valid, vert_idx, is_new, table_full, input ready);
   modport sink (input valid, vert_idx, is_new, table_full, output ready);
endinterface

// ----- sv/vdi_store.sv -----
// Position store: one synchronous RAM of packed positions with a registered read.
// Depends on vdi_pkg.
module vdi_store (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [vdi_pkg::AddrW-1:0]  wr_addr,
   input  vdi_pkg::pos_type           wr_data,
   input  logic [vdi_pkg::AddrW-1:0]  rd_addr,
   output vdi_pkg::pos_type           rd_data
);
   vdi_pkg::pos_type mem [vdi_pkg::MaxVertices];
   vdi_pkg::pos_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ----- sv/vertex_dedup_indexer_core.sv -----
// Vertex deduplication indexer: linear scan of stored positions, one read+compare per entry.
// Each stored entry is read in ST_READ and compared in ST_CMP; a hit goes to ST_RESP, and a new
// or rejected position goes there from ST_READ once the scan reaches the stored count. The
// block takes a new request only in ST_IDLE, after the response transaction is done.
// A clear is taken in ST_IDLE and gives no result.
// Synchronous active-high reset clears the count and control; RAM is left.
module vertex_dedup_indexer_core (
   input  logic      clock,
   input  logic      reset,
   vdi_req_if.sink   req,
   vdi_rsp_if.source rsp
);
   localparam int AW = vdi_pkg::AddrW;
   localparam int CW = vdi_pkg::CountW;

   vdi_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] scan_ff, scan_in;
   vdi_pkg::pos_type key_ff, key_in;
   logic [vdi_pkg::IndexW-1:0] idx_ff, idx_in;
   logic new_ff, new_in, full_ff, full_in;

   logic wr_en;
   vdi_pkg::pos_type rd_data;
   logic hit;

   vdi_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (key_ff),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign hit = (rd_data == key_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vdi_pkg::ST_IDLE:
            if (req.valid && req.action == vdi_pkg::ActVertex) state_in = vdi_pkg::ST_READ;
         vdi_pkg::ST_READ:
            // Nothing left to read: finish as a miss.
            if (scan_ff == count_ff) state_in = vdi_pkg::ST_RESP;
            else state_in = vdi_pkg::ST_CMP;
         vdi_pkg::ST_CMP:
            if (hit) state_in = vdi_pkg::ST_RESP;
            else state_in = vdi_pkg::ST_READ;
         vdi_pkg::ST_RESP:
            if (rsp.ready) state_in = vdi_pkg::ST_IDLE;
         default: state_in = vdi_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      count_in = count_ff;
      scan_in  = scan_ff;
      key_in   = key_ff;
      idx_in   = idx_ff;
      new_in   = new_ff;
      full_in  = full_ff;
      wr_en    = 1'b0;
      req.ready = (state_ff == vdi_pkg::ST_IDLE);
      unique case (state_ff)
         vdi_pkg::ST_IDLE:
            if (req.valid) begin
               if (req.action == vdi_pkg::ActClear) count_in = '0;
               key_in.x = vdi_pkg::canon_zero(req.pos_x);
               key_in.y = vdi_pkg::canon_zero(req.pos_y);
               key_in.z = vdi_pkg::canon_zero(req.pos_z);
               scan_in = '0;
            end
         vdi_pkg::ST_READ:
            if (scan_ff == count_ff) begin
               // Miss: store if room, else flag full.
               if (count_ff == CW'(vdi_pkg::MaxVertices)) begin
                  idx_in = '0; new_in = 1'b0; full_in = 1'b1;
               end else begin
                  wr_en = 1'b1;
                  idx_in = vdi_pkg::IndexW'(count_ff);
                  new_in = 1'b1; full_in = 1'b0;
                  count_in = count_ff + 1'b1;
               end
            end
         vdi_pkg::ST_CMP:
            if (hit) begin
               idx_in = vdi_pkg::IndexW'(scan_ff);
               new_in = 1'b0; full_in = 1'b0;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         vdi_pkg::ST_RESP: ;
         default: ;
      endcase
   end

   assign rsp.valid = (state_ff == vdi_pkg::ST_RESP);
   assign rsp.vert_idx = idx_ff;
   assign rsp.is_new = new_ff;
   assign rsp.table_full = full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vdi_pkg::ST_IDLE;
         count_ff <= '0;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         scan_ff  <= scan_in;
      end
      key_ff  <= key_in;
      idx_ff  <= idx_in;
      new_ff  <= new_in;
      full_ff <= full_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(vdi_pkg::MaxVertices)) else $error("count overflow");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      scan_ff <= count_ff) else $error("scan past count");
   a_new_idx: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.is_new |-> !rsp.table_full &&
      CW'(rsp.vert_idx) == CW'(count_ff - 1'b1)) else $error("new index");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.vert_idx))
      else $error("response dropped");
endmodule

// ----- bench/tb_vertex_dedup_indexer_core.sv -----
// Self-checking bench for vertex_dedup_indexer_core: directed and random-model traffic.
// Depends on vdi_pkg and the vdi_req_if / vdi_rsp_if interfaces from the RTL.
// Expected indexes come from a behavioral dedup table inside the bench.
module tb_vertex_dedup_indexer_core;
   localparam int SlowestVertex = 2 + 2 * vdi_pkg::MaxVertices + 40;

   // One expected result transaction.
   typedef struct {
      bit [vdi_pkg::IndexW-1:0] vert_idx;
      bit                       is_new;
      bit                       table_full;
   } index_result_type;

   // Dedup table shadow plus the queue of index results still owed by the block.
   class index_book;
      bit [vdi_pkg::CoordW-1:0] seen_x [vdi_pkg::MaxVertices];
      bit [vdi_pkg::CoordW-1:0] seen_y [vdi_pkg::MaxVertices];
      bit [vdi_pkg::CoordW-1:0] seen_z [vdi_pkg::MaxVertices];
      int                       seen_count;
      index_result_type         owed [$];
      int                       errors;
      int                       checked;
      int                       fresh_seen;
      int                       full_seen;
      int                       clears_seen;

      function new();
         seen_count = 0;
         errors = 0;
         checked = 0;
         fresh_seen = 0;
         full_seen = 0;
         clears_seen = 0;
      endfunction

      task report(input string msg);
         errors++;
         $display("[%0t] mismatch: %s", $time, msg);
      endtask

      function bit [vdi_pkg::CoordW-1:0] fold_zero(input bit [vdi_pkg::CoordW-1:0] v);
         return (v == {1'b1, {(vdi_pkg::CoordW-1){1'b0}}}) ? '0 : v;
      endfunction

      // Work out what one accepted request transaction will produce.
      function void note_request(input logic act, input bit [vdi_pkg::CoordW-1:0] px,
                                 input bit [vdi_pkg::CoordW-1:0] py,
                                 input bit [vdi_pkg::CoordW-1:0] pz);
         bit [vdi_pkg::CoordW-1:0] x, y, z;
         index_result_type r;
         int i;
         if (act == vdi_pkg::ActClear) begin
            seen_count = 0;
            clears_seen++;
            return;
         end
         x = fold_zero(px);
         y = fold_zero(py);
         z = fold_zero(pz);
         for (i = 0; i < seen_count; i++) begin
            if (seen_x[i] == x && seen_y[i] == y && seen_z[i] == z) begin
               r.vert_idx = i[vdi_pkg::IndexW-1:0];
               r.is_new = 1'b0;
               r.table_full = 1'b0;
               owed = {owed, r};
               return;
            end
         end
         if (seen_count >= vdi_pkg::MaxVertices) begin
            r.vert_idx = '0;
            r.is_new = 1'b0;
            r.table_full = 1'b1;
            owed = {owed, r};
            return;
         end
         seen_x[seen_count] = x;
         seen_y[seen_count] = y;
         seen_z[seen_count] = z;
         r.vert_idx = seen_count[vdi_pkg::IndexW-1:0];
         r.is_new = 1'b1;
         r.table_full = 1'b0;
         seen_count++;
         owed = {owed, r};
      endfunction

      task check_response(input logic [vdi_pkg::IndexW-1:0] idx, input logic fresh,
                          input logic full);
         index_result_type e;
         if (owed.size() == 0) begin
            report($sformatf("unexpected result index=%0d new=%b full=%b", idx, fresh, full));
            return;
         end
         e = owed.pop_front();
         checked++;
         if (fresh === 1'b1) fresh_seen++;
         if (full === 1'b1) full_seen++;
         if (idx !== e.vert_idx)
            report($sformatf("vert_idx %0d, want %0d", idx, e.vert_idx));
         if (fresh !== e.is_new)
            report($sformatf("is_new %b, want %b (index %0d)", fresh, e.is_new, e.vert_idx));
         if (full !== e.table_full)
            report($sformatf("table_full %b, want %b", full, e.table_full));
      endtask

      function int depth();
         return owed.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   sender_idles;
   bit   receiver_stalls;
   int   sent_vertices;
   int   sent_items;
   index_book book;

   vdi_req_if req_ch ();
   vdi_rsp_if rsp_ch ();

   vertex_dedup_indexer_core u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // Drive the response ready at the falling edge; stall only when enabled.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= receiver_stalls ? (pick_gap() == 0) : 1'b1;
      end
   end

   // Sample results at the rising edge, before the block updates its outputs.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         book.check_response(rsp_ch.vert_idx, rsp_ch.is_new, rsp_ch.table_full);
   end

   // Present one request transaction, hold it until accepted, then note it.
   // Valid stays high into the next call when no gap follows.
   task automatic send_item(input logic act, input bit [vdi_pkg::CoordW-1:0] x,
                            input bit [vdi_pkg::CoordW-1:0] y,
                            input bit [vdi_pkg::CoordW-1:0] z);
      int gap;
      gap = sender_idles ? pick_gap() : 0;
      repeat (gap) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.action <= act;
      req_ch.pos_x  <= x;
      req_ch.pos_y  <= y;
      req_ch.pos_z  <= z;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      book.note_request(act, x, y, z);
      sent_items++;
      if (act == vdi_pkg::ActVertex) sent_vertices++;
      @(negedge clock);
   endtask

   task automatic send_vertex(input bit [vdi_pkg::CoordW-1:0] x,
                              input bit [vdi_pkg::CoordW-1:0] y,
                              input bit [vdi_pkg::CoordW-1:0] z);
      send_item(vdi_pkg::ActVertex, x, y, z);
   endtask

   task automatic send_clear();
      send_item(vdi_pkg::ActClear, $urandom(), $urandom(), $urandom());
   endtask

   // Hold the sender until every owed result has come back.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (book.depth() != 0) @(negedge clock);
   endtask

   // Coordinate with a bias toward signed zeros and NaN patterns.
   function bit [vdi_pkg::CoordW-1:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'h8000_0000;
         2: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'hFF, 1'b1, 22'($urandom())};
         default: return $urandom();
      endcase
   endfunction

   // Flip a zero coordinate to the other sign; leave others alone.
   function bit [vdi_pkg::CoordW-1:0] flip_zero(input bit [vdi_pkg::CoordW-1:0] v);
      if (v[vdi_pkg::CoordW-2:0] == '0)
         return {~v[vdi_pkg::CoordW-1], v[vdi_pkg::CoordW-2:0]};
      return v;
   endfunction

   // Stimulus.
   initial begin
      bit [vdi_pkg::CoordW-1:0] pool_x [$], pool_y [$], pool_z [$];
      int n_uniq, n_items, pick, i, k;

      book = new();
      sent_vertices = 0;
      sent_items = 0;
      sender_idles = 1'b1;
      receiver_stalls = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.action = vdi_pkg::ActClear;
      req_ch.pos_x = '0;
      req_ch.pos_y = '0;
      req_ch.pos_z = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: signed zeros, extremes, NaN, lookalikes of zero, clear.
      send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_vertex(32'h8000_0000, 32'h0000_0000, 32'h8000_0000);
      send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_vertex(32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000);
      send_vertex(32'h7FC0_0000, 32'h3F80_0000, 32'h0000_0000);
      send_vertex(32'h7FC0_0000, 32'h3F80_0000, 32'h8000_0000);
      send_vertex(32'hFFC0_0000, 32'h3F80_0000, 32'h0000_0000);
      send_vertex(32'h8000_0001, 32'h0000_0000, 32'h0000_0000);
      send_vertex(32'h0000_0001, 32'h8000_0000, 32'h8000_0000);
      send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_clear();
      send_clear();
      send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_vertex(32'h8000_0000, 32'h8000_0000, 32'h0000_0000);
      send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_vertex(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);

      // Pause the sender once so the block runs dry mid-model.
      drain();

      // Random models: mostly a clear, then repeats drawn from a small pool of positions.
      while (sent_items < 430) begin
         sender_idles = ($urandom_range(0, 3) != 0);
         receiver_stalls = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 5) != 0) send_clear();
         pool_x.delete();
         pool_y.delete();
         pool_z.delete();
         n_uniq = $urandom_range(1, 24);
         for (i = 0; i < n_uniq; i++) begin
            pool_x = {pool_x, pick_coord()};
            pool_y = {pool_y, pick_coord()};
            pool_z = {pool_z, pick_coord()};
         end
         n_items = $urandom_range(4, 40);
         for (i = 0; i < n_items; i++) begin
            k = $urandom_range(0, 19);
            if (k == 0) begin
               send_vertex($urandom(), $urandom(), $urandom());
            end else if (k == 1) begin
               send_clear();
            end else begin
               pick = $urandom_range(0, n_uniq - 1);
               send_vertex($urandom_range(0, 1) ? flip_zero(pool_x[pick]) : pool_x[pick],
                           $urandom_range(0, 1) ? flip_zero(pool_y[pick]) : pool_y[pick],
                           $urandom_range(0, 1) ? flip_zero(pool_z[pick]) : pool_z[pick]);
            end
         end
      end

      // Short closing model with repeats across a clear.
      sender_idles = 1'b1;
      receiver_stalls = 1'b1;
      send_clear();
      send_vertex(32'h8000_0000, 32'hFFFF_FFFF, 32'h3F80_0000);
      send_vertex(32'h0000_03FF, 32'hFFFF_FC00, 32'h3F80_0000);
      send_vertex(32'h1234_5678, 32'h0000_0000, 32'h0000_0000);
      send_vertex(32'h7FC0_0000, 32'h7FC0_0000, 32'h7FC0_0000);
      send_vertex(32'h0000_0000, 32'hFFFF_FFFF, 32'h3F80_0000);
      send_clear();
      send_vertex(32'h1234_5678, 32'h8000_0000, 32'h0000_0000);
      send_vertex(32'h1234_5678, 32'h0000_0000, 32'h8000_0000);

      // Let the last lookup finish, then allow a full scan's worth of slack.
      drain();
      repeat (SlowestVertex) @(negedge clock);

      $display("Covered %0d transactions: %0d vertices, %0d clears.",
               sent_items, sent_vertices, book.clears_seen);
      $display("Checked %0d results, %0d new, %0d full.",
               book.checked, book.fresh_seen, book.full_seen);
      if (book.errors == 0 && book.depth() == 0) begin
         $display("** vertex_dedup_indexer_core: PASSED **");
      end else begin
         $display("%0d errors, %0d results never arrived", book.errors, book.depth());
         $display("** vertex_dedup_indexer_core: FAILED **");
      end
      $finish;
   end

   // Watchdog: full-table scans on every vertex with the longest stalls stay well below this.
   initial begin
      #60_000_000;
      $display("timeout with %0d results outstanding", book.depth());
      $display("** vertex_dedup_indexer_core: FAILED **");
      $finish;
   end
endmodule
